>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; the user scope supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SBSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sbsr_pkg.sv
// ----------------------------------------------------------------------------
// sbsr_pkg
// Types, constants and the request frame byte table of the sync-read engine.
// ----------------------------------------------------------------------------
package sbsr_pkg;

  localparam int SERVOS = 6;
  localparam int FRAME_LEN = SERVOS + 8;
  localparam int IDX_W = 4;

  localparam logic [7:0] SYNC_BYTE      = 8'hFF;
  localparam logic [7:0] BROADCAST_ID   = 8'hFE;
  localparam logic [7:0] INST_SYNC_READ = 8'h82;
  localparam logic [7:0] READ_LEN       = 8'd2;
  localparam logic [7:0] STATUS_LEN     = 8'd4;
  localparam logic [7:0] CMD_LEN        = 8'(SERVOS + 4);
  localparam logic [7:0] SERVOS_B       = 8'(SERVOS);

  localparam int BASE_SUM_I = 254 + SERVOS + 4 + 130 + 2 + SERVOS * (SERVOS + 1) / 2;
  localparam logic [7:0] BASE_SUM  = 8'(BASE_SUM_I % 256);
  localparam logic [7:0] FULL_MASK = 8'((1 << SERVOS) - 1);

  localparam logic [IDX_W-1:0] IDX_ADDR  = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_ID0   = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);

  localparam logic [2:0] FP_HUNT  = 3'd0;
  localparam logic [2:0] FP_SYNC1 = 3'd1;
  localparam logic [2:0] FP_BODY  = 3'd2;
  localparam logic [2:0] FP_CHECK = 3'd7;

  localparam logic RK_TX     = 1'b0;
  localparam logic RK_REPORT = 1'b1;

  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_POS_ADDR = 1'b1;

  typedef enum logic [1:0] {
    KIND_RX_BYTE  = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_RX_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic        report_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  servo_index;
    logic [15:0] position;
    logic [7:0]  update_seq;
    logic        round_complete;
  } result_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] tx_byte;
    logic       last;
  } gen_status_t;

  function automatic logic [7:0] req_byte(input logic [IDX_W-1:0] idx,
                                          input logic [7:0] addr);
    logic [7:0] b;
    b = SYNC_BYTE;
    if (idx == IDX_LAST) begin
      b = ~(BASE_SUM + addr);
    end else if (idx >= IDX_ID0) begin
      b = 8'(idx - IDX_ID0) + 8'd1;
    end else if (idx == IDX_W'(6)) begin
      b = READ_LEN;
    end else if (idx == IDX_ADDR) begin
      b = addr;
    end else if (idx == IDX_W'(4)) begin
      b = INST_SYNC_READ;
    end else if (idx == IDX_W'(3)) begin
      b = CMD_LEN;
    end else if (idx == IDX_W'(2)) begin
      b = BROADCAST_ID;
    end
    return b;
  endfunction

endpackage

>>> hdl/sbsr_if.sv
// ----------------------------------------------------------------------------
// sbsr_if
// Valid/ready channels of the sync-read engine.
// ----------------------------------------------------------------------------
interface sbsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface sbsr_out_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  servo_index;
  logic [15:0] position;
  logic [7:0]  update_seq;
  logic        round_complete;
  modport source (output valid, output report_kind, output tx_byte, output last,
                  output servo_index, output position, output update_seq,
                  output round_complete, input ready);
  modport sink (input valid, input report_kind, input tx_byte, input last,
                input servo_index, input position, input update_seq,
                input round_complete, output ready);
endinterface

interface sbsr_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/sbsr_req_gen.sv
// ----------------------------------------------------------------------------
// sbsr_req_gen
// Request frame sequencer: walks the frame bytes after the first one.
// ----------------------------------------------------------------------------
module sbsr_req_gen (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                advance,
  input  logic [7:0]          position_address,
  output sbsr_pkg::gen_status_t status
);

  logic                       busy_r, busy_nxt;
  logic [sbsr_pkg::IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = sbsr_pkg::IDX_FIRST;
    end else if (busy_r && advance) begin
      if (idx_r == sbsr_pkg::IDX_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign status.busy    = busy_r;
  assign status.tx_byte = sbsr_pkg::req_byte(idx_r, position_address);
  assign status.last    = (idx_r == sbsr_pkg::IDX_LAST);

endmodule

>>> hdl/servo_bus_sync_read_engine.sv
// ----------------------------------------------------------------------------
// servo_bus_sync_read_engine_core
// Sync-read master: request frame transmit and status frame receive.
// ----------------------------------------------------------------------------
// Received bytes, ticks and receive errors are taken one per clock, each
// finished in the cycle it is accepted, with at most one report landing in the
// single output register, which presents it the cycle after acceptance. Any
// input waits while that register holds a result the sink has not taken. An
// accepted request that is not blocked emits SERVOS+8 transmit transactions,
// one per cycle the output register drains; the input stalls for the SERVOS+7
// of them after the first, since the frame bytes share that register.
// A blocked request is consumed with no result. Configuration writes are
// taken every cycle.
module servo_bus_sync_read_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  sbsr_in_if.sink     in_ch,
  sbsr_out_if.source  out_ch,
  sbsr_cfg_if.sink    cfg_ch
);

  logic [7:0]  timeout_r;
  logic [7:0]  pos_addr_r;
  logic [2:0]  frame_pos_r, frame_pos_nxt;
  logic [7:0]  frame_bytes_r [5];
  logic [7:0]  seq_r [8];
  logic        pending_r, pending_nxt;
  logic [7:0]  answered_r, answered_nxt;
  logic [7:0]  elapsed_r, elapsed_nxt;
  logic        out_valid_r, out_valid_nxt;
  sbsr_pkg::result_t out_r, out_nxt;

  sbsr_pkg::gen_status_t gen;
  sbsr_pkg::kind_t       kind;

  logic        slot_free;
  logic        in_acc;
  logic        store_byte;
  logic        seq_bump;
  logic        req_start;
  logic        frame_ok;
  logic [7:0]  chk;
  logic [7:0]  id;
  logic [2:0]  sidx;
  logic [7:0]  seq_new;
  logic [7:0]  ans_new;

  assign kind      = sbsr_pkg::kind_t'(in_ch.kind);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !gen.busy && slot_free;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign id      = frame_bytes_r[0];
  assign chk     = ~(frame_bytes_r[0] + frame_bytes_r[1] + frame_bytes_r[2]
                     + frame_bytes_r[3] + frame_bytes_r[4]);
  assign frame_ok = (frame_bytes_r[1] == sbsr_pkg::STATUS_LEN) && (in_ch.rx_byte == chk)
                    && (id != 8'd0) && (id <= sbsr_pkg::SERVOS_B);
  assign sidx    = 3'(id - 8'd1);
  assign seq_new = seq_r[sidx] + 8'd1;
  assign ans_new = answered_r | (8'd1 << sidx);

  sbsr_req_gen u_req_gen (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (req_start),
    .advance          (slot_free),
    .position_address (pos_addr_r),
    .status           (gen)
  );

  always_comb begin
    frame_pos_nxt = frame_pos_r;
    pending_nxt   = pending_r;
    answered_nxt  = answered_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    store_byte    = 1'b0;
    seq_bump      = 1'b0;
    req_start     = 1'b0;
    if (gen.busy && slot_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      out_nxt.report_kind = sbsr_pkg::RK_TX;
      out_nxt.tx_byte     = gen.tx_byte;
      out_nxt.last        = gen.last;
    end
    if (in_acc) begin
      case (kind)
        sbsr_pkg::KIND_RX_BYTE: begin
          if (frame_pos_r == sbsr_pkg::FP_HUNT) begin
            if (in_ch.rx_byte == sbsr_pkg::SYNC_BYTE) begin
              frame_pos_nxt = sbsr_pkg::FP_SYNC1;
            end
          end else if (frame_pos_r == sbsr_pkg::FP_SYNC1) begin
            frame_pos_nxt = (in_ch.rx_byte == sbsr_pkg::SYNC_BYTE) ? sbsr_pkg::FP_BODY
                                                                   : sbsr_pkg::FP_HUNT;
          end else if (frame_pos_r == sbsr_pkg::FP_CHECK) begin
            frame_pos_nxt = sbsr_pkg::FP_HUNT;
            if (frame_ok) begin
              seq_bump      = 1'b1;
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
              out_nxt.report_kind = sbsr_pkg::RK_REPORT;
              out_nxt.last        = 1'b1;
              out_nxt.servo_index = sidx;
              out_nxt.position    = {frame_bytes_r[4], frame_bytes_r[3]};
              out_nxt.update_seq  = seq_new;
              if (pending_r) begin
                answered_nxt = ans_new;
                if ((ans_new & sbsr_pkg::FULL_MASK) == sbsr_pkg::FULL_MASK) begin
                  pending_nxt = 1'b0;
                  out_nxt.round_complete = 1'b1;
                end
              end
            end
          end else begin
            store_byte    = 1'b1;
            frame_pos_nxt = frame_pos_r + 3'd1;
          end
        end
        sbsr_pkg::KIND_REQUEST: begin
          if (!(pending_r && (elapsed_r < timeout_r))) begin
            req_start     = 1'b1;
            pending_nxt   = 1'b1;
            answered_nxt  = '0;
            elapsed_nxt   = '0;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.report_kind = sbsr_pkg::RK_TX;
            out_nxt.tx_byte     = sbsr_pkg::SYNC_BYTE;
          end
        end
        sbsr_pkg::KIND_TICK: begin
          if (elapsed_r != 8'hFF) begin
            elapsed_nxt = elapsed_r + 8'd1;
          end
        end
        default: begin
          frame_pos_nxt = sbsr_pkg::FP_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= 8'd5;
      pos_addr_r  <= 8'd56;
      frame_pos_r <= sbsr_pkg::FP_HUNT;
      pending_r   <= 1'b0;
      answered_r  <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        seq_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          sbsr_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_ch.data;
          sbsr_pkg::CFG_POS_ADDR: pos_addr_r <= cfg_ch.data;
          default: ;
        endcase
      end
      frame_pos_r <= frame_pos_nxt;
      pending_r   <= pending_nxt;
      answered_r  <= answered_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      if (seq_bump) begin
        seq_r[sidx] <= seq_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (store_byte) begin
      frame_bytes_r[3'(frame_pos_r - sbsr_pkg::FP_BODY)] <= in_ch.rx_byte;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.report_kind    = out_r.report_kind;
  assign out_ch.tx_byte        = out_r.tx_byte;
  assign out_ch.last           = out_r.last;
  assign out_ch.servo_index    = out_r.servo_index;
  assign out_ch.position       = out_r.position;
  assign out_ch.update_seq     = out_r.update_seq;
  assign out_ch.round_complete = out_r.round_complete;

endmodule

>>> hdl/sbsr_checker.sv
// ----------------------------------------------------------------------------
// sbsr_checker
// Port-level checks of the sync-read engine, bound to the engine core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_report_kind,
  input logic [7:0]  out_tx_byte,
  input logic        out_last,
  input logic [2:0]  out_servo_index,
  input logic [15:0] out_position,
  input logic [7:0]  out_update_seq,
  input logic        out_round_complete
);

  `SBSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tx_byte) && $stable(out_position) && $stable(out_last), "stalled result changed")
  `SBSR_ASSERT_NOW(a_report_shape, out_valid && out_report_kind == sbsr_pkg::RK_REPORT, out_last && out_tx_byte == 8'd0, "report not a lone transaction")
  `SBSR_ASSERT_NOW(a_tx_shape, out_valid && out_report_kind == sbsr_pkg::RK_TX, out_servo_index == 3'd0 && out_position == 16'd0 && out_update_seq == 8'd0 && !out_round_complete, "transmit byte carries report fields")
  `SBSR_ASSERT_NOW(a_frame_blocks_in, out_valid && out_report_kind == sbsr_pkg::RK_TX && !out_last, !in_ready, "input taken during request frame")

endmodule

bind servo_bus_sync_read_engine_core sbsr_checker u_sbsr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_report_kind    (out_ch.report_kind),
  .out_tx_byte        (out_ch.tx_byte),
  .out_last           (out_ch.last),
  .out_servo_index    (out_ch.servo_index),
  .out_position       (out_ch.position),
  .out_update_seq     (out_ch.update_seq),
  .out_round_complete (out_ch.round_complete)
);
